>>> rtl/core/weight_on_wheels_flight_timer_defines.svh
// Assertion macros for the weight-on-wheels flight timer.
`ifndef WEIGHT_ON_WHEELS_FLIGHT_TIMER_DEFINES_SVH
`define WEIGHT_ON_WHEELS_FLIGHT_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define WOWFT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wowft check failed");
// Next-cycle implication, checked at every rising clock edge out of reset.
`define WOWFT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wowft check failed");
`else
`define WOWFT_ASSERT_NOW(label, ante, cons)
`define WOWFT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/wowft_pkg.sv
// Package with the shared types and constants of the weight-on-wheels flight timer.
package wowft_pkg;

	// Width of all time stamps and elapsed times.
	localparam int TIME_BITS = 32;
	// Width of the confirmation time register.
	localparam int CFG_BITS = 16;
	// Confirmation time after reset, in milliseconds.
	localparam logic [CFG_BITS-1:0] CONFIRM_RESET = CFG_BITS'(2);

	// Pending confirmation code; the unused code reads as none pending.
	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_TAKEOFF = 2'd1,
		MODE_LANDING = 2'd2
	} mode_t;

	// Architectural state carried from one word to the next.
	typedef struct packed {
		logic                 airborne;
		mode_t                confirm_state;
		logic [TIME_BITS-1:0] window_start;
		logic [TIME_BITS-1:0] ground_stamp;
		logic [TIME_BITS-1:0] flight_elapsed;
		logic [TIME_BITS-1:0] flight_record;
	} state_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic                 on_ground;
		logic [1:0]           pending_mode;
		logic [TIME_BITS-1:0] current_flight_ms;
		logic [TIME_BITS-1:0] longest_flight_ms;
		logic [TIME_BITS-1:0] last_ground_ms;
		logic                 switch_echo;
	} result_t;

endpackage

>>> rtl/core/wowft_sample_if.sv
// Channel interface for switch samples.
interface wowft_sample_if;
	import wowft_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 switch_closed;
	logic [TIME_BITS-1:0] now_ms;

	modport source (output valid, output switch_closed, output now_ms, input ready);
	modport sink (input valid, input switch_closed, input now_ms, output ready);
endinterface

>>> rtl/core/wowft_result_if.sv
// Channel interface for status and timer results.
interface wowft_result_if;
	import wowft_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 on_ground;
	logic [1:0]           pending_mode;
	logic [TIME_BITS-1:0] current_flight_ms;
	logic [TIME_BITS-1:0] longest_flight_ms;
	logic [TIME_BITS-1:0] last_ground_ms;
	logic                 switch_echo;

	modport source (
		output valid, output on_ground, output pending_mode, output current_flight_ms,
		output longest_flight_ms, output last_ground_ms, output switch_echo, input ready
	);
	modport sink (
		input valid, input on_ground, input pending_mode, input current_flight_ms,
		input longest_flight_ms, input last_ground_ms, input switch_echo, output ready
	);
endinterface

>>> rtl/core/wowft_cfg_if.sv
// Write channel interface for the confirmation time register.
interface wowft_cfg_if;
	import wowft_pkg::*;

	logic                valid;
	logic                ready;
	logic [CFG_BITS-1:0] confirm_ms;

	modport source (output valid, output confirm_ms, input ready);
	modport sink (input valid, input confirm_ms, output ready);
endinterface

>>> rtl/core/weight_on_wheels_flight_timer.sv
// Top level of the weight-on-wheels flight timer: sample register, update logic, result register.
`include "weight_on_wheels_flight_timer_defines.svh"

// Debounces a ground-contact switch against a programmable confirmation time and
// tracks flight time. Every sample word yields exactly one result word. A sample is
// captured in an input register and, in the cycle it moves on, the update logic reads
// the confirmed status and timers, computes the new values and loads them together
// with the result register. A sample passes the input register, then the result
// register. One sample per cycle is sustained while results are taken, limited by the
// status update that each sample needs from the one before it. While a result waits,
// an empty input register still takes one sample. The confirmation time register may
// be written at any cycle while no sample is in flight; it is always ready.
module weight_on_wheels_flight_timer (
	input logic            clk,
	input logic            arst_n,
	wowft_sample_if.sink   sample,
	wowft_result_if.source result,
	wowft_cfg_if.sink      cfg
);
	import wowft_pkg::*;

	logic                 valid_s1;
	logic                 sw_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 valid_s2;
	result_t              res_s2;
	state_t               state_q;
	logic [CFG_BITS-1:0]  confirm_q;
	state_t               state_nxt;
	result_t              res_nxt;
	logic                 adv;
	logic                 s2_free;

	// Handshake: the pipeline moves whenever the next stage is empty or drained.
	assign s2_free      = !valid_s2 || result.ready;
	assign adv          = valid_s1 && s2_free;
	assign sample.ready = !valid_s1 || s2_free;
	assign cfg.ready    = 1'b1;

	// Confirmation time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q <= CONFIRM_RESET;
		end else if (cfg.valid) begin
			confirm_q <= cfg.confirm_ms;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sw_s1  <= sample.switch_closed;
			now_s1 <= sample.now_ms;
		end
	end

	// Status and timer update.
	wowft_step u_step (
		.cur        (state_q),
		.confirm_ms (confirm_q),
		.sw         (sw_s1),
		.now        (now_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				airborne: 1'b0, confirm_state: MODE_NONE, window_start: '0,
				ground_stamp: '0, flight_elapsed: '0, flight_record: '0
			};
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid             = valid_s2;
	assign result.on_ground         = res_s2.on_ground;
	assign result.pending_mode      = res_s2.pending_mode;
	assign result.current_flight_ms = res_s2.current_flight_ms;
	assign result.longest_flight_ms = res_s2.longest_flight_ms;
	assign result.last_ground_ms    = res_s2.last_ground_ms;
	assign result.switch_echo       = res_s2.switch_echo;

	// Consistency checks on the status and timers.
	`WOWFT_ASSERT_NOW(a_record_covers_flight, 1'b1, state_q.flight_record >= state_q.flight_elapsed)
	`WOWFT_ASSERT_NOW(a_idle_window_clear, state_q.confirm_state == MODE_NONE, state_q.window_start == '0)
	`WOWFT_ASSERT_NOW(a_landing_from_air, state_q.confirm_state == MODE_LANDING, state_q.airborne)
	`WOWFT_ASSERT_NOW(a_takeoff_from_ground, state_q.confirm_state == MODE_TAKEOFF, !state_q.airborne)
	`WOWFT_ASSERT_NEXT(a_state_holds_on_stall, !adv, $stable(state_q))
endmodule

>>> rtl/core/wowft_step.sv
// Next-state and result logic for one switch sample.
module wowft_step (
	input  wowft_pkg::state_t                    cur,
	input  logic [wowft_pkg::CFG_BITS-1:0]       confirm_ms,
	input  logic                                 sw,
	input  logic [wowft_pkg::TIME_BITS-1:0]      now,
	output wowft_pkg::state_t                    nxt,
	output wowft_pkg::result_t                   res
);
	import wowft_pkg::*;

	logic [TIME_BITS-1:0] held;
	logic [TIME_BITS-1:0] air_elapsed;
	logic                 expired;
	logic                 go_ground;
	logic                 go_air;
	logic                 close_window;

	// Time since the window opened and since the last ground contact, modulo the wrap.
	assign held        = now - cur.window_start;
	assign air_elapsed = now - cur.ground_stamp;
	assign expired     = held > TIME_BITS'(confirm_ms);

	// Decide the transition for this sample.
	always_comb begin
		go_ground    = 1'b0;
		go_air       = 1'b0;
		close_window = 1'b0;
		nxt          = cur;
		unique case (cur.confirm_state)
			MODE_LANDING: begin
				if (sw) begin
					go_ground    = expired;
					close_window = expired;
				end else begin
					close_window = 1'b1;
					go_air       = 1'b1;
				end
			end
			MODE_TAKEOFF: begin
				if (!sw) begin
					go_air       = expired;
					close_window = expired;
				end else begin
					close_window = 1'b1;
					go_ground    = 1'b1;
				end
			end
			default: begin
				nxt.confirm_state = MODE_NONE;
				if (sw && cur.airborne) begin
					nxt.confirm_state = MODE_LANDING;
					nxt.window_start  = now;
				end else if (!sw && !cur.airborne) begin
					nxt.confirm_state = MODE_TAKEOFF;
					nxt.window_start  = now;
				end else begin
					go_ground = sw;
					go_air    = !sw;
				end
			end
		endcase

		if (close_window) begin
			nxt.confirm_state = MODE_NONE;
			nxt.window_start  = '0;
		end
		if (go_ground) begin
			nxt.airborne     = 1'b0;
			nxt.ground_stamp = now;
		end
		if (go_air) begin
			nxt.airborne       = 1'b1;
			nxt.flight_elapsed = air_elapsed;
			if (air_elapsed > cur.flight_record) begin
				nxt.flight_record = air_elapsed;
			end
		end
	end

	// Result word reflects the state after the update.
	always_comb begin
		res.on_ground         = !nxt.airborne;
		res.pending_mode      = nxt.confirm_state;
		res.current_flight_ms = nxt.flight_elapsed;
		res.longest_flight_ms = nxt.flight_record;
		res.last_ground_ms    = nxt.ground_stamp;
		res.switch_echo       = sw;
	end
endmodule

>>> test/tb_weight_on_wheels_flight_timer.sv
// Testbench for the weight-on-wheels flight timer: predicts each status word and checks it.
module tb_weight_on_wheels_flight_timer;
	import wowft_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_PER_PHASE = 285;

	// Opening walk with confirm_ms at its reset value: {switch_closed, now_ms}.
	localparam logic [32:0] OPENING_WALK [23] = '{
		{1'b1, 32'd0}, {1'b1, 32'hFFFF_FFFF}, {1'b1, 32'd5}, {1'b0, 32'd10},
		{1'b0, 32'd12}, {1'b1, 32'd13}, {1'b0, 32'd20}, {1'b0, 32'd23},
		{1'b0, 32'd30}, {1'b1, 32'd31}, {1'b0, 32'd32}, {1'b1, 32'd40},
		{1'b1, 32'd42}, {1'b1, 32'd43}, {1'b0, 32'hFFFF_FFF0}, {1'b0, 32'd5},
		{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'd100}, {1'b1, 32'hFFFF_FFFE}, {1'b1, 32'd3},
		{1'b0, 32'd3}, {1'b0, 32'd5}, {1'b1, 32'd5}
	};

	// Tracks the debounced status and flight timers and holds the status words still due.
	class wow_status_book;
		logic [CFG_BITS-1:0]  confirm_ms;
		logic                 airborne;
		mode_t                confirm_state;
		logic [TIME_BITS-1:0] window_start;
		logic [TIME_BITS-1:0] ground_stamp;
		logic [TIME_BITS-1:0] flight_elapsed;
		logic [TIME_BITS-1:0] flight_record;
		result_t              due_q[$];
		int                   errors;

		function new();
			confirm_ms = CONFIRM_RESET;
			airborne = 1'b0;
			confirm_state = MODE_NONE;
			window_start = '0;
			ground_stamp = '0;
			flight_elapsed = '0;
			flight_record = '0;
			errors = 0;
		endfunction

		function void touch_down(logic [TIME_BITS-1:0] now);
			airborne = 1'b0;
			ground_stamp = now;
		endfunction

		function void lift_off(logic [TIME_BITS-1:0] now);
			airborne = 1'b1;
			flight_elapsed = now - ground_stamp;
			if (flight_elapsed > flight_record) begin
				flight_record = flight_elapsed;
			end
		endfunction

		// Advances the status by one accepted sample and queues the word it yields.
		function void note_sample(logic sw, logic [TIME_BITS-1:0] now);
			logic [TIME_BITS-1:0] held;
			result_t              due;
			held = now - window_start;
			case (confirm_state)
				MODE_LANDING: begin
					if (sw) begin
						if (held > TIME_BITS'(confirm_ms)) begin
							touch_down(now);
							confirm_state = MODE_NONE;
							window_start = '0;
						end
					end else begin
						confirm_state = MODE_NONE;
						window_start = '0;
						lift_off(now);
					end
				end
				MODE_TAKEOFF: begin
					if (!sw) begin
						if (held > TIME_BITS'(confirm_ms)) begin
							lift_off(now);
							confirm_state = MODE_NONE;
							window_start = '0;
						end
					end else begin
						confirm_state = MODE_NONE;
						window_start = '0;
						touch_down(now);
					end
				end
				default: begin
					// Nothing pending: a level against the status opens a window.
					confirm_state = MODE_NONE;
					if (sw) begin
						if (airborne) begin
							confirm_state = MODE_LANDING;
							window_start = now;
						end else begin
							touch_down(now);
						end
					end else begin
						if (!airborne) begin
							confirm_state = MODE_TAKEOFF;
							window_start = now;
						end else begin
							lift_off(now);
						end
					end
				end
			endcase
			due.on_ground = !airborne;
			due.pending_mode = confirm_state;
			due.current_flight_ms = flight_elapsed;
			due.longest_flight_ms = flight_record;
			due.last_ground_ms = ground_stamp;
			due.switch_echo = sw;
			due_q.push_back(due);
		endfunction

		// Compares one delivered word with the oldest one due.
		function void check_status(result_t got);
			result_t due;
			if (due_q.size() == 0) begin
				$error("status word with none due: %h", got);
				errors++;
				return;
			end
			due = due_q.pop_front();
			if (got.on_ground !== due.on_ground) begin
				$error("on_ground: expected %0d, got %0d", due.on_ground, got.on_ground);
				errors++;
			end
			if (got.pending_mode !== due.pending_mode) begin
				$error("pending_mode: expected %0d, got %0d", due.pending_mode, got.pending_mode);
				errors++;
			end
			if (got.current_flight_ms !== due.current_flight_ms) begin
				$error("current_flight_ms: expected %h, got %h",
					due.current_flight_ms, got.current_flight_ms);
				errors++;
			end
			if (got.longest_flight_ms !== due.longest_flight_ms) begin
				$error("longest_flight_ms: expected %h, got %h",
					due.longest_flight_ms, got.longest_flight_ms);
				errors++;
			end
			if (got.last_ground_ms !== due.last_ground_ms) begin
				$error("last_ground_ms: expected %h, got %h",
					due.last_ground_ms, got.last_ground_ms);
				errors++;
			end
			if (got.switch_echo !== due.switch_echo) begin
				$error("switch_echo: expected %0d, got %0d", due.switch_echo, got.switch_echo);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wowft_sample_if sample_ch ();
	wowft_result_if result_ch ();
	wowft_cfg_if    cfg_ch ();

	weight_on_wheels_flight_timer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	wow_status_book book = new();
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_req;
	int  hold_left;
	int  quiet_cycles;

	always #6 clk = ~clk;

	// Offers one sample word, idling first at random, and notes it once accepted.
	task automatic send_sample(logic sw, logic [TIME_BITS-1:0] now);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.switch_closed <= sw;
		sample_ch.now_ms <= now;
		@(posedge clk);
		while (!sample_ch.ready) begin
			@(posedge clk);
		end
		book.note_sample(sw, now);
	endtask

	// Stops offering and waits until every due status word has come out.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (book.due_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_confirm(logic [CFG_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.confirm_ms <= value;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		book.confirm_ms = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// Time step between samples, with the confirmation boundary hit often.
	function automatic logic [TIME_BITS-1:0] pick_step();
		case ($urandom_range(0, 7))
			0: return TIME_BITS'(book.confirm_ms);
			1: return TIME_BITS'(book.confirm_ms) + 1;
			2: return '0;
			default: return $urandom_range(0, book.confirm_ms / 2 + 3);
		endcase
	endfunction

	// Flights and landings with bounces, plus some samples at random times.
	task automatic run_flights(int count);
		logic [TIME_BITS-1:0] now;
		logic                 level;
		logic                 sw;
		int                   run_left;
		now = $urandom;
		level = 1'($urandom_range(0, 1));
		run_left = 0;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				send_sample(1'($urandom_range(0, 1)), $urandom);
			end else begin
				if (run_left == 0) begin
					level = !level;
					run_left = $urandom_range(1, 8);
				end
				sw = level;
				if ($urandom_range(0, 11) == 0) begin
					sw = !level;
				end
				now = now + pick_step();
				send_sample(sw, now);
				run_left--;
			end
		end
	endtask

	// Result side: checks every accepted word and stalls at random or on request.
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			book.check_status('{result_ch.on_ground, result_ch.pending_mode,
				result_ch.current_flight_ms, result_ch.longest_flight_ms,
				result_ch.last_ground_ms, result_ch.switch_echo});
		end
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.switch_closed = 1'b0;
		sample_ch.now_ms = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.confirm_ms = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk at the reset confirmation time.
		foreach (OPENING_WALK[i]) begin
			send_sample(OPENING_WALK[i][32], OPENING_WALK[i][31:0]);
		end
		drain();

		// Zero confirmation time, no idling, and one long hold on the result side.
		write_confirm('0);
		hold_req = 1'b1;
		run_flights(RANDOM_PER_PHASE);
		drain();

		// Longest confirmation time with an idle sender.
		write_confirm('1);
		send_idle_pct = 66;
		run_flights(RANDOM_PER_PHASE);
		drain();

		// Random confirmation time with a stalling receiver.
		write_confirm(CFG_BITS'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 66;
		run_flights(RANDOM_PER_PHASE);
		drain();

		// Reset value again with both sides idling now and then.
		write_confirm(CONFIRM_RESET);
		send_idle_pct = 23;
		recv_stall_pct = 23;
		run_flights(RANDOM_PER_PHASE);
		drain();

		// Short confirmation times at full rate.
		write_confirm(CFG_BITS'($urandom_range(1, 20)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_flights(RANDOM_PER_PHASE);
		drain();

		if (book.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
